### src/link_liveness_tracker_top_assert.svh
// ----------------------------------------------------------------------------
// Link liveness tracker assertion macros
// Short forms for the concurrent checks placed at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef LINK_LIVENESS_TRACKER_TOP_ASSERT_SVH
`define LINK_LIVENESS_TRACKER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LLTR_ASSERT_IMPLIES(name, clk_i, rstn_i, ante, cons) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("lltr: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LLTR_ASSERT_NEXT(name, clk_i, rstn_i, ante, cons) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("lltr: next-cycle check failed");

`endif

### src/lltr_pkg.sv
// ----------------------------------------------------------------------------
// Link liveness tracker package
// Shared constants, codes and word types for the tracker modules.
// ----------------------------------------------------------------------------
package lltr_pkg;

	// Table geometry.
	localparam int LINKS   = 8;
	localparam int LINK_AW = (LINKS > 1) ? $clog2(LINKS) : 1;

	// Field widths.
	localparam int TIME_W  = 40;
	localparam int RUN_W   = 16;
	localparam int TMS_W   = 22;
	localparam int GRACE_W = 27;
	localparam int CDOWN_W = 26;
	localparam int CNT_W   = 4;
	localparam int CFG_AW  = 3;
	localparam int CFG_DW  = 12;

	// Arithmetic constants.
	localparam logic [9:0]         MS_PER_S    = 10'd1000;
	localparam logic [GRACE_W-1:0] WARN_MIN_MS = 27'd3000;
	localparam logic [RUN_W-1:0]   RUN_MAX     = '1;
	localparam logic [CDOWN_W-1:0] CDOWN_MAX   = '1;

	// Operation codes.
	localparam logic [2:0] OP_POLL    = 3'd0;
	localparam logic [2:0] OP_CONNECT = 3'd1;
	localparam logic [2:0] OP_OFFLINE = 3'd2;
	localparam logic [2:0] OP_SOCKET  = 3'd3;
	localparam logic [2:0] OP_READY   = 3'd4;
	localparam logic [2:0] OP_QUERY   = 3'd5;

	// Link state codes.
	localparam logic [1:0] ST_UNKNOWN      = 2'd0;
	localparam logic [1:0] ST_CONNECTING   = 2'd1;
	localparam logic [1:0] ST_CONNECTED    = 2'd2;
	localparam logic [1:0] ST_DISCONNECTED = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_AW-1:0] CFG_TIMEOUT    = 3'd0;
	localparam logic [CFG_AW-1:0] CFG_GRACE_MULT = 3'd1;
	localparam logic [CFG_AW-1:0] CFG_MIN_FAIL   = 3'd2;
	localparam logic [CFG_AW-1:0] CFG_NOTICES    = 3'd3;
	localparam logic [CFG_AW-1:0] CFG_MUTED      = 3'd4;

	// Configuration reset values (timeout kept as milliseconds).
	localparam logic [TMS_W-1:0]   RST_TIMEOUT_MS = 22'd30000;
	localparam logic [4:0]         RST_GRACE_MULT = 5'd3;
	localparam logic [7:0]         RST_MIN_FAIL   = 8'd2;
	localparam logic               RST_NOTICES    = 1'b1;
	localparam logic [7:0]         RST_MUTED      = 8'd0;
	localparam logic [GRACE_W-1:0] RST_WINDOW_MS  = 27'd90000;

	// Input word.
	typedef struct packed {
		logic [2:0]        op;
		logic [2:0]        link;
		logic              flag;
		logic [TIME_W-1:0] event_time_ms;
	} in_word_t;

	// Result word.
	typedef struct packed {
		logic [1:0]         link_state;
		logic               state_changed;
		logic               outage_start;
		logic               warning_shown;
		logic [CDOWN_W-1:0] countdown_ms;
		logic               recovered_shown;
		logic               went_offline;
		logic               socket_up;
		logic               data_ready;
		logic [TIME_W-1:0]  last_seen_ms;
		logic [CNT_W-1:0]   connected_count;
	} out_word_t;

	// One table entry per link.
	typedef struct packed {
		logic [1:0]        state;
		logic [RUN_W-1:0]  fail_run;
		logic [RUN_W-1:0]  succ_run;
		logic [TIME_W-1:0] last_ok;
		logic              warned;
		logic              ready;
		logic              socket;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Live configuration seen by the update logic.
	typedef struct packed {
		logic [GRACE_W-1:0] window_ms;
		logic [7:0]         min_failures;
		logic               notices_enabled;
		logic [7:0]         muted_links;
	} cfg_t;

	// Quiet-time summary computed one stage ahead of the update.
	typedef struct packed {
		logic               seen;
		logic               big;
		logic [GRACE_W-1:0] quiet;
	} quiet_t;

endpackage

### src/lltr_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module lltr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     wen,
	input  logic [AW-1:0]            waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     ren,
	input  logic [AW-1:0]            raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wen) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; returns the old word on a same-address write.
	always_ff @(posedge clk) begin
		if (ren) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### src/lltr_cfg.sv
// ----------------------------------------------------------------------------
// Link liveness tracker configuration registers
// Holds the registers and derives the grace window in milliseconds.
// ----------------------------------------------------------------------------
module lltr_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [lltr_pkg::CFG_AW-1:0] cfg_addr,
	input  logic [lltr_pkg::CFG_DW-1:0] cfg_wdata,
	output lltr_pkg::cfg_t              cfg
);

	logic [lltr_pkg::TMS_W-1:0]   timeout_ms_q;
	logic [4:0]                   grace_mult_q;
	logic [7:0]                   min_fail_q;
	logic                         notices_q;
	logic [7:0]                   muted_q;
	logic [lltr_pkg::GRACE_W-1:0] grace_q;
	logic [lltr_pkg::TMS_W-1:0]   timeout_prod;
	logic [lltr_pkg::GRACE_W-1:0] grace_prod;

	// The timeout is scaled to milliseconds as it is written.
	assign timeout_prod = {10'b0, cfg_wdata} * {12'b0, lltr_pkg::MS_PER_S};

	// The grace window is a registered product of the timeout and multiplier registers.
	assign grace_prod = {5'b0, timeout_ms_q} * {22'b0, grace_mult_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_ms_q <= lltr_pkg::RST_TIMEOUT_MS;
			grace_mult_q <= lltr_pkg::RST_GRACE_MULT;
			min_fail_q   <= lltr_pkg::RST_MIN_FAIL;
			notices_q    <= lltr_pkg::RST_NOTICES;
			muted_q      <= lltr_pkg::RST_MUTED;
			grace_q      <= lltr_pkg::RST_WINDOW_MS;
		end else begin
			grace_q <= grace_prod;
			if (cfg_wen) begin
				case (cfg_addr)
					lltr_pkg::CFG_TIMEOUT:    timeout_ms_q <= timeout_prod;
					lltr_pkg::CFG_GRACE_MULT: grace_mult_q <= cfg_wdata[4:0];
					lltr_pkg::CFG_MIN_FAIL:   min_fail_q   <= cfg_wdata[7:0];
					lltr_pkg::CFG_NOTICES:    notices_q    <= cfg_wdata[0];
					lltr_pkg::CFG_MUTED:      muted_q      <= cfg_wdata[7:0];
					default: begin
					end
				endcase
			end
		end
	end

	assign cfg.window_ms       = grace_q;
	assign cfg.min_failures    = min_fail_q;
	assign cfg.notices_enabled = notices_q;
	assign cfg.muted_links     = muted_q;

endmodule

### src/lltr_update.sv
// ----------------------------------------------------------------------------
// Link liveness tracker entry update
// Applies one event to a table entry and forms the result word.
// ----------------------------------------------------------------------------
module lltr_update (
	input  lltr_pkg::in_word_t  word,
	input  lltr_pkg::entry_t    entry,
	input  lltr_pkg::quiet_t    quiet,
	input  lltr_pkg::cfg_t      cfg,
	output lltr_pkg::entry_t    nxt,
	output lltr_pkg::out_word_t res
);

	logic                         notice_on;
	logic [lltr_pkg::GRACE_W:0]   grace_diff;
	logic                         quiet_ge;
	logic [lltr_pkg::GRACE_W-1:0] left_ms;
	logic [lltr_pkg::RUN_W-1:0]   fail_inc;
	logic [lltr_pkg::RUN_W-1:0]   succ_inc;
	logic                         start;
	logic                         recovered;

	// Notices need the global enable and an unmuted link.
	assign notice_on = cfg.notices_enabled & ~cfg.muted_links[word.link];

	// One subtract gives both the grace compare and the time left.
	assign grace_diff = {1'b0, cfg.window_ms} - {1'b0, quiet.quiet};
	assign quiet_ge   = quiet.big | grace_diff[lltr_pkg::GRACE_W] | (grace_diff == '0);
	assign left_ms    = quiet_ge ? '0 : grace_diff[lltr_pkg::GRACE_W-1:0];

	// Saturating run counters.
	assign fail_inc = (entry.fail_run == lltr_pkg::RUN_MAX) ? entry.fail_run
		: entry.fail_run + 1'b1;
	assign succ_inc = (entry.succ_run == lltr_pkg::RUN_MAX) ? entry.succ_run
		: entry.succ_run + 1'b1;

	always_comb begin
		nxt       = entry;
		res       = '0;
		start     = 1'b0;
		recovered = 1'b0;

		// Operation dispatch.
		case (word.op)
			lltr_pkg::OP_POLL: begin
				if (word.flag) begin
					nxt.succ_run = succ_inc;
					nxt.fail_run = '0;
					nxt.last_ok  = word.event_time_ms;
					if (entry.state == lltr_pkg::ST_CONNECTED) begin
						if (entry.warned) begin
							recovered  = 1'b1;
							nxt.warned = 1'b0;
						end
					end else begin
						nxt.state = lltr_pkg::ST_CONNECTED;
					end
				end else begin
					nxt.fail_run = fail_inc;
					nxt.succ_run = '0;
					if (entry.state inside {lltr_pkg::ST_UNKNOWN, lltr_pkg::ST_CONNECTING}) begin
						nxt.state = lltr_pkg::ST_DISCONNECTED;
					end else if (entry.state == lltr_pkg::ST_CONNECTED) begin
						if (quiet.seen && quiet_ge && (fail_inc >= {8'b0, cfg.min_failures})) begin
							nxt.state = lltr_pkg::ST_DISCONNECTED;
							nxt.ready = 1'b0;
						end else if (fail_inc == 16'd1) begin
							start = 1'b1;
						end
					end else begin
						nxt.ready = 1'b0;
					end
				end
			end
			lltr_pkg::OP_CONNECT: begin
				if (entry.state == lltr_pkg::ST_UNKNOWN) begin
					nxt.state = lltr_pkg::ST_CONNECTING;
				end
			end
			lltr_pkg::OP_OFFLINE: begin
				if (entry.state != lltr_pkg::ST_DISCONNECTED) begin
					nxt.state    = lltr_pkg::ST_DISCONNECTED;
					nxt.ready    = 1'b0;
					nxt.fail_run = '0;
					nxt.succ_run = '0;
					nxt.warned   = 1'b0;
				end
			end
			lltr_pkg::OP_SOCKET: begin
				nxt.socket = word.flag;
			end
			lltr_pkg::OP_READY: begin
				nxt.ready = word.flag;
			end
			default: begin
				// Query and unused codes leave the entry alone.
			end
		endcase

		// Outage start and the optional countdown warning.
		if (start) begin
			res.outage_start = 1'b1;
			if (notice_on && (left_ms > lltr_pkg::WARN_MIN_MS)) begin
				nxt.warned        = 1'b1;
				res.warning_shown = 1'b1;
				res.countdown_ms  = left_ms[lltr_pkg::GRACE_W-1] ? lltr_pkg::CDOWN_MAX
					: left_ms[lltr_pkg::CDOWN_W-1:0];
			end
		end

		res.recovered_shown = recovered & notice_on;

		// A poll that demotes a connected link drops its warning.
		if ((word.op == lltr_pkg::OP_POLL) && (entry.state == lltr_pkg::ST_CONNECTED)
				&& (nxt.state == lltr_pkg::ST_DISCONNECTED)) begin
			nxt.warned       = 1'b0;
			res.went_offline = 1'b1;
		end

		res.link_state    = nxt.state;
		res.state_changed = (nxt.state != entry.state);
		res.socket_up     = nxt.socket;
		res.data_ready    = nxt.ready;
		res.last_seen_ms  = nxt.last_ok;
	end

endmodule

### src/link_liveness_tracker_top.sv
// ----------------------------------------------------------------------------
// Link liveness tracker
// Per-link liveness table with one read-modify-write per event.
// ----------------------------------------------------------------------------
// Usage:
//   Events enter on in_valid/in_word, results leave on out_valid/out_word.
//   A word moves when valid is high and stall is low at a rising edge.
//   Every event gives exactly one result word, in order.
//   The link table lives in an 8-entry RAM with a registered read.
//   The entry of an accepted word is read at the accepting edge, its quiet
//   time is formed in the next cycle, and when the update stage advances
//   the entry is written back as the result is loaded into the output
//   register. One event is in flight at a time, a limit set by the RAM
//   read-modify-write loop, so no new word is taken while an event sits
//   in the read stage or waits in the update stage. A new word may be
//   accepted while the previous result waits; a same-link access right
//   after a write is served from a forwarding register.
//   When out_stall holds the output register full, the event in the
//   update stage waits and in_stall stays high until the slot frees.
//   Reset clears the valid bits of the table, so every link reads as
//   unknown with zero runs and flags; the configuration returns to its
//   defaults. Configuration writes take effect for the next event.
// ----------------------------------------------------------------------------
module link_liveness_tracker_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  lltr_pkg::in_word_t          in_word,
	output logic                        out_valid,
	input  logic                        out_stall,
	output lltr_pkg::out_word_t         out_word,
	input  logic                        cfg_wen,
	input  logic [lltr_pkg::CFG_AW-1:0] cfg_addr,
	input  logic [lltr_pkg::CFG_DW-1:0] cfg_wdata
);

	lltr_pkg::cfg_t      cfg;
	logic                in_accept;
	logic                s2_adv;
	logic                v_s1;
	lltr_pkg::in_word_t  word_s1;
	logic                v_s2;
	lltr_pkg::in_word_t  word_s2;
	lltr_pkg::entry_t    entry_s2;
	lltr_pkg::quiet_t    quiet_s2;
	logic [lltr_pkg::ENTRY_W-1:0] ram_rdata;
	lltr_pkg::entry_t    entry_s1;
	lltr_pkg::quiet_t    quiet_s1;
	logic [lltr_pkg::LINK_AW-1:0] addr_s1;
	logic [lltr_pkg::LINK_AW-1:0] addr_s2;
	logic                fwd_hit;
	logic [lltr_pkg::TIME_W:0]    time_diff;
	logic [lltr_pkg::TIME_W-1:0]  quiet_full;
	logic [lltr_pkg::LINKS-1:0]   valid_q;
	logic                fwd_valid_q;
	logic [lltr_pkg::LINK_AW-1:0] fwd_addr_q;
	lltr_pkg::entry_t    fwd_data_q;
	lltr_pkg::entry_t    entry_nxt;
	lltr_pkg::out_word_t upd_res;
	logic                in_range;
	logic                wr_en;
	logic [lltr_pkg::CNT_W-1:0]   cnt_q;
	logic [lltr_pkg::CNT_W-1:0]   cnt_nxt;
	logic                out_valid_q;
	lltr_pkg::out_word_t out_word_q;
	lltr_pkg::out_word_t out_nxt;

	// Configuration registers and grace window.
	lltr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Handshake: one event in flight, output register decouples the receiver.
	assign s2_adv    = v_s2 & (~out_valid_q | ~out_stall);
	assign in_stall  = v_s1 | (v_s2 & ~s2_adv);
	assign in_accept = in_valid & ~in_stall;

	assign addr_s1  = word_s1.link[lltr_pkg::LINK_AW-1:0];
	assign addr_s2  = word_s2.link[lltr_pkg::LINK_AW-1:0];
	assign in_range = (int'(word_s2.link) < lltr_pkg::LINKS);
	assign wr_en    = s2_adv & in_range;

	// Link table.
	lltr_ram #(
		.WIDTH (lltr_pkg::ENTRY_W),
		.DEPTH (lltr_pkg::LINKS)
	) u_table (
		.clk   (clk),
		.wen   (wr_en),
		.waddr (addr_s2),
		.wdata (entry_nxt),
		.ren   (in_accept),
		.raddr (in_word.link[lltr_pkg::LINK_AW-1:0]),
		.rdata (ram_rdata)
	);

	// Entry select: latest write wins, never-written entries read as reset.
	assign fwd_hit  = fwd_valid_q && (fwd_addr_q == addr_s1);
	assign entry_s1 = fwd_hit ? fwd_data_q
		: (valid_q[addr_s1] ? lltr_pkg::entry_t'(ram_rdata) : '0);

	// Quiet time since the last success, zero if never seen or time ran back.
	assign time_diff  = {1'b0, word_s1.event_time_ms} - {1'b0, entry_s1.last_ok};
	assign quiet_s1.seen = (entry_s1.last_ok != '0);
	assign quiet_full = (!quiet_s1.seen || time_diff[lltr_pkg::TIME_W]) ? '0
		: time_diff[lltr_pkg::TIME_W-1:0];
	assign quiet_s1.big   = |quiet_full[lltr_pkg::TIME_W-1:lltr_pkg::GRACE_W];
	assign quiet_s1.quiet = quiet_full[lltr_pkg::GRACE_W-1:0];

	// Stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_accept;
			v_s2 <= v_s1 | (v_s2 & ~s2_adv);
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			word_s1 <= in_word;
		end
		if (v_s1) begin
			word_s2  <= word_s1;
			entry_s2 <= entry_s1;
			quiet_s2 <= quiet_s1;
		end
	end

	// Event update.
	lltr_update u_update (
		.word  (word_s2),
		.entry (entry_s2),
		.quiet (quiet_s2),
		.cfg   (cfg),
		.nxt   (entry_nxt),
		.res   (upd_res)
	);

	// Connected-link count follows state moves into and out of connected.
	always_comb begin
		cnt_nxt = cnt_q;
		if (in_range) begin
			if ((entry_s2.state != lltr_pkg::ST_CONNECTED)
					&& (entry_nxt.state == lltr_pkg::ST_CONNECTED)) begin
				cnt_nxt = cnt_q + 1'b1;
			end else if ((entry_s2.state == lltr_pkg::ST_CONNECTED)
					&& (entry_nxt.state != lltr_pkg::ST_CONNECTED)) begin
				cnt_nxt = cnt_q - 1'b1;
			end
		end
	end

	// Valid bits, forwarding register and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			fwd_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else if (s2_adv) begin
			cnt_q <= cnt_nxt;
			if (wr_en) begin
				valid_q[addr_s2] <= 1'b1;
				fwd_valid_q      <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q <= addr_s2;
			fwd_data_q <= entry_nxt;
		end
	end

	// Result word with the updated link count.
	always_comb begin
		out_nxt                 = in_range ? upd_res : '0;
		out_nxt.connected_count = cnt_nxt;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			out_word_q <= out_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// Checks.
`include "link_liveness_tracker_top_assert.svh"

	`LLTR_ASSERT_IMPLIES(a_single_in_flight, clk, arst_n, v_s1, !v_s2)
	`LLTR_ASSERT_NEXT(a_accept_reads, clk, arst_n, in_accept, v_s1)
	`LLTR_ASSERT_NEXT(a_update_loads_out, clk, arst_n, s2_adv, out_valid_q && !v_s2)
	`LLTR_ASSERT_IMPLIES(a_count_bound, clk, arst_n, out_valid_q, int'(cnt_q) <= lltr_pkg::LINKS)

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link liveness tracker testbench
// Sends event words through the tracker and checks every result word
// against a cycle-free model of the link table kept in the testbench. The
// run covers each operation, outage warnings and demotions, register
// extremes and random traffic under back-pressure.
// ----------------------------------------------------------------------------
module tb;
	import lltr_pkg::*;

	// Operation codes that the block treats as a query.
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;

	localparam int unsigned LIMIT_CYCLES = 1_000_000;
	localparam int unsigned HOLD_CYCLES  = 200;
	localparam int unsigned MAX_REPORTS  = 10;
	localparam int unsigned RANDOM_ITEMS = 100;

	typedef enum logic [1:0] {RX_FLOW, RX_RANDOM, RX_PERIODIC, RX_HEAVY} rx_pattern_e;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	in_word_t            in_word;
	logic                out_valid;
	logic                out_stall;
	out_word_t           out_word;
	logic                cfg_wen;
	logic [CFG_AW-1:0]   cfg_addr;
	logic [CFG_DW-1:0]   cfg_wdata;

	// Model copy of the link table and the live registers.
	logic [1:0]        lk_state  [LINKS];
	logic [RUN_W-1:0]  lk_fail   [LINKS];
	logic [RUN_W-1:0]  lk_succ   [LINKS];
	logic [TIME_W-1:0] lk_last   [LINKS];
	logic              lk_warned [LINKS];
	logic              lk_ready  [LINKS];
	logic              lk_socket [LINKS];
	logic [11:0]       cfg_timeout;
	logic [4:0]        cfg_mult;
	logic [7:0]        cfg_min_fail;
	logic              cfg_notices;
	logic [7:0]        cfg_muted;

	out_word_t   pending_results[$];
	int unsigned mismatch_count;
	logic [TIME_W-1:0] now_ms;
	bit          tx_idle_on;
	int unsigned burst_left;
	logic        rx_idle_on;
	logic        hold_go;

	link_liveness_tracker_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_wen   (cfg_wen),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	// Clock with a 2 ns period.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Applies one event to the model table and returns the result word it gives.
	function automatic out_word_t advance_link_table(in_word_t w);
		out_word_t       r;
		logic [1:0]      prev;
		int unsigned     k;
		longint unsigned grace, quiet, left, last_ok, ts;
		bit              notices, outage, recovered;
		r = '0;
		k = w.link;
		prev = lk_state[k];
		ts = w.event_time_ms;
		notices = cfg_notices && !cfg_muted[k];
		outage = 1'b0;
		recovered = 1'b0;
		left = 0;
		case (w.op)
			OP_POLL: begin
				if (w.flag) begin
					if (lk_succ[k] != RUN_MAX)
						lk_succ[k]++;
					lk_fail[k] = '0;
					lk_last[k] = w.event_time_ms;
					if (prev == ST_CONNECTED) begin
						if (lk_warned[k]) begin
							recovered = 1'b1;
							lk_warned[k] = 1'b0;
						end
					end else begin
						lk_state[k] = ST_CONNECTED;
					end
				end else begin
					if (lk_fail[k] != RUN_MAX)
						lk_fail[k]++;
					lk_succ[k] = '0;
					if (prev == ST_UNKNOWN || prev == ST_CONNECTING) begin
						lk_state[k] = ST_DISCONNECTED;
					end else if (prev == ST_CONNECTED) begin
						// A link never seen has no quiet time and is never demoted.
						grace = 64'(cfg_timeout) * MS_PER_S * 64'(cfg_mult);
						last_ok = lk_last[k];
						quiet = (last_ok != 0 && ts >= last_ok) ? ts - last_ok : 0;
						if (last_ok != 0 && quiet >= grace && lk_fail[k] >= cfg_min_fail) begin
							lk_state[k] = ST_DISCONNECTED;
							lk_ready[k] = 1'b0;
						end else if (lk_fail[k] == 1) begin
							outage = 1'b1;
							left = (grace > quiet) ? grace - quiet : 0;
						end
					end else begin
						lk_ready[k] = 1'b0;
					end
				end
				if (outage) begin
					r.outage_start = 1'b1;
					if (notices && left > WARN_MIN_MS) begin
						lk_warned[k] = 1'b1;
						r.warning_shown = 1'b1;
						r.countdown_ms = (left > CDOWN_MAX) ? CDOWN_MAX : CDOWN_W'(left);
					end
				end
				r.recovered_shown = recovered && notices;
				if (prev == ST_CONNECTED && lk_state[k] == ST_DISCONNECTED) begin
					lk_warned[k] = 1'b0;
					r.went_offline = 1'b1;
				end
			end
			OP_CONNECT: begin
				if (prev == ST_UNKNOWN)
					lk_state[k] = ST_CONNECTING;
			end
			OP_OFFLINE: begin
				if (prev != ST_DISCONNECTED) begin
					lk_state[k] = ST_DISCONNECTED;
					lk_ready[k] = 1'b0;
					lk_fail[k] = '0;
					lk_succ[k] = '0;
					lk_warned[k] = 1'b0;
				end
			end
			OP_SOCKET: lk_socket[k] = w.flag;
			OP_READY:  lk_ready[k] = w.flag;
			default: ;
		endcase
		r.link_state = lk_state[k];
		r.state_changed = (lk_state[k] != prev);
		r.socket_up = lk_socket[k];
		r.data_ready = lk_ready[k];
		r.last_seen_ms = lk_last[k];
		for (int i = 0; i < LINKS; i++)
			if (lk_state[i] == ST_CONNECTED)
				r.connected_count++;
		return r;
	endfunction

	function automatic string word_text(out_word_t w);
		return $sformatf({"st=%0d chg=%0d out=%0d warn=%0d cd=%0d rec=%0d off=%0d",
			" sock=%0d rdy=%0d seen=%0d cnt=%0d"},
			w.link_state, w.state_changed, w.outage_start, w.warning_shown,
			w.countdown_ms, w.recovered_shown, w.went_offline, w.socket_up,
			w.data_ready, w.last_seen_ms, w.connected_count);
	endfunction

	// Sends one event word, with random gaps between bursts, and records its result.
	task automatic post_event(input logic [2:0] op, input logic [2:0] link,
			input logic flag, input logic [TIME_W-1:0] ts);
		in_word_t    w;
		int unsigned gap;
		w.op = op;
		w.link = link;
		w.flag = flag;
		w.event_time_ms = ts;
		if (tx_idle_on && burst_left == 0) begin
			gap = $urandom_range(0, 6);
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(advance_link_table(w));
	endtask

	// Stops sending and waits until every expected result word has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	// Writes all five registers while the block is idle.
	task automatic configure(input logic [11:0] tmo, input logic [4:0] mult,
			input logic [7:0] min_fail, input logic notices, input logic [7:0] muted);
		drain_results();
		cfg_wen <= 1'b1;
		cfg_addr <= CFG_TIMEOUT;
		cfg_wdata <= tmo;
		@(posedge clk);
		cfg_addr <= CFG_GRACE_MULT;
		cfg_wdata <= CFG_DW'(mult);
		@(posedge clk);
		cfg_addr <= CFG_MIN_FAIL;
		cfg_wdata <= CFG_DW'(min_fail);
		@(posedge clk);
		cfg_addr <= CFG_NOTICES;
		cfg_wdata <= CFG_DW'(notices);
		@(posedge clk);
		cfg_addr <= CFG_MUTED;
		cfg_wdata <= CFG_DW'(muted);
		@(posedge clk);
		cfg_wen <= 1'b0;
		cfg_timeout = tmo;
		cfg_mult = mult;
		cfg_min_fail = min_fail;
		cfg_notices = notices;
		cfg_muted = muted;
	endtask

	// Every operation on fresh links, including the codes that act as a query.
	task automatic test_basic_ops();
		post_event(OP_QUERY,   3'd0, 1'b0, 40'd0);
		post_event(OP_SPARE6,  3'd7, 1'b1, 40'hFF_FFFF_FFFF);
		post_event(OP_SPARE7,  3'd1, 1'b0, 40'd100);
		post_event(OP_CONNECT, 3'd0, 1'b0, 40'd200);
		post_event(OP_CONNECT, 3'd0, 1'b1, 40'd300);
		post_event(OP_SOCKET,  3'd0, 1'b1, 40'd400);
		post_event(OP_READY,   3'd0, 1'b1, 40'd500);
		post_event(OP_POLL,    3'd0, 1'b0, 40'd600);
		post_event(OP_POLL,    3'd0, 1'b0, 40'd700);
		post_event(OP_READY,   3'd0, 1'b1, 40'd800);
		post_event(OP_OFFLINE, 3'd0, 1'b0, 40'd900);
		post_event(OP_POLL,    3'd0, 1'b1, 40'd5000);
		post_event(OP_OFFLINE, 3'd0, 1'b1, 40'd6000);
		post_event(OP_SOCKET,  3'd0, 1'b0, 40'd7000);
		post_event(OP_POLL,    3'd5, 1'b0, 40'd8000);
		// A success stamped at time zero leaves the link looking never seen.
		post_event(OP_POLL,    3'd7, 1'b1, 40'd0);
		post_event(OP_OFFLINE, 3'd6, 1'b0, 40'd9000);
	endtask

	// Outage start, warning, recovery, demotion and the notice gate.
	task automatic test_outage_paths();
		post_event(OP_POLL, 3'd1, 1'b1, 40'd1000);
		post_event(OP_POLL, 3'd1, 1'b0, 40'd2000);
		post_event(OP_POLL, 3'd1, 1'b1, 40'd3000);
		post_event(OP_POLL, 3'd1, 1'b0, 40'd100000);
		post_event(OP_POLL, 3'd1, 1'b0, 40'd100001);
		// Time running backwards gives a quiet time of zero.
		post_event(OP_POLL, 3'd2, 1'b1, 40'd50000);
		post_event(OP_POLL, 3'd2, 1'b0, 40'd10000);
		// Warning threshold: exactly 3000 ms left is not enough, 3001 is.
		post_event(OP_POLL, 3'd3, 1'b1, 40'd10000);
		post_event(OP_POLL, 3'd3, 1'b0, 40'd97000);
		post_event(OP_POLL, 3'd3, 1'b1, 40'd97001);
		post_event(OP_POLL, 3'd3, 1'b0, 40'd184000);
		// Never-seen link: warned with the full window, never demoted.
		post_event(OP_POLL, 3'd7, 1'b0, 40'd1000000000);
		post_event(OP_POLL, 3'd7, 1'b0, 40'd1000000001);
		configure(12'd30, 5'd3, 8'd2, 1'b1, 8'h14);
		post_event(OP_POLL, 3'd2, 1'b1, 40'd60000);
		post_event(OP_POLL, 3'd4, 1'b1, 40'd1000);
		post_event(OP_POLL, 3'd4, 1'b0, 40'd2000);
	endtask

	// Register values at the limits of their field widths.
	task automatic test_register_extremes();
		configure(12'd4095, 5'd31, 8'd255, 1'b1, 8'h00);
		post_event(OP_POLL, 3'd3, 1'b1, 40'd1000000);
		post_event(OP_POLL, 3'd3, 1'b0, 40'd1000001);
		post_event(OP_POLL, 3'd3, 1'b0, 40'd200000000);
		configure(12'd0, 5'd0, 8'd0, 1'b1, 8'hFF);
		post_event(OP_POLL, 3'd3, 1'b0, 40'd200000010);
		post_event(OP_POLL, 3'd4, 1'b1, 40'd300);
		post_event(OP_POLL, 3'd4, 1'b0, 40'd300);
		configure(12'd1, 5'd1, 8'd1, 1'b0, 8'h00);
		post_event(OP_POLL, 3'd5, 1'b1, 40'd10000);
		post_event(OP_POLL, 3'd5, 1'b0, 40'd10010);
		post_event(OP_POLL, 3'd5, 1'b0, 40'd20000);
		configure(12'd30, 5'd3, 8'd2, 1'b1, 8'h00);
	endtask

	// Random events, mostly on one focus link so that outages run deep.
	task automatic test_random_traffic(input int unsigned n_items);
		longint unsigned   grace;
		int unsigned       step_max, focus, roll, back;
		logic [2:0]        op, lk;
		logic              flg;
		logic [TIME_W-1:0] ts;
		grace = 64'(cfg_timeout) * MS_PER_S * 64'(cfg_mult);
		step_max = 32'(grace / 6) + 200;
		focus = $urandom_range(0, LINKS - 1);
		repeat (n_items) begin
			if ($urandom_range(0, 15) == 0)
				focus = $urandom_range(0, LINKS - 1);
			lk = ($urandom_range(0, 9) < 7) ? 3'(focus) : 3'($urandom_range(0, LINKS - 1));
			flg = 1'($urandom_range(0, 1));
			roll = $urandom_range(0, 99);
			if (roll < 60) begin
				op = OP_POLL;
				flg = ($urandom_range(0, 9) < 4);
			end else if (roll < 68) begin
				op = OP_CONNECT;
			end else if (roll < 73) begin
				op = OP_OFFLINE;
			end else if (roll < 81) begin
				op = OP_SOCKET;
			end else if (roll < 89) begin
				op = OP_READY;
			end else begin
				case ($urandom_range(0, 2))
					0: op = OP_QUERY;
					1: op = OP_SPARE6;
					default: op = OP_SPARE7;
				endcase
			end
			now_ms += $urandom_range(0, step_max);
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				ts = {8'($urandom), $urandom};
			end else if (roll < 7) begin
				back = $urandom_range(1, step_max * 4);
				ts = (now_ms > back) ? now_ms - back : '0;
			end else if (roll < 8) begin
				ts = '0;
			end else begin
				ts = now_ms;
			end
			post_event(op, lk, flg, ts);
		end
	endtask

	// Random traffic under several register settings, reset defaults first.
	task automatic test_random_phases();
		test_random_traffic(RANDOM_ITEMS);
		configure(12'($urandom_range(1, 10)), 5'($urandom_range(1, 3)),
			8'($urandom_range(1, 4)), 1'b1, 8'($urandom));
		test_random_traffic(RANDOM_ITEMS);
		configure(12'($urandom_range(1, 3600)), 5'($urandom_range(1, 16)),
			8'($urandom_range(1, 6)), 1'b0, 8'h00);
		test_random_traffic(RANDOM_ITEMS);
		configure(12'($urandom_range(1, 3600)), 5'($urandom_range(1, 16)),
			8'($urandom_range(1, 255)), 1'b1, 8'($urandom));
		test_random_traffic(RANDOM_ITEMS);
	endtask

	// The receiver holds off for a long stretch while words keep coming.
	task automatic test_backpressure();
		configure(12'd2, 5'd2, 8'd2, 1'b1, 8'h00);
		tx_idle_on = 1'b0;
		hold_go <= 1'b1;
		test_random_traffic(40);
		hold_go <= 1'b0;
		tx_idle_on = 1'b1;
	endtask

	// Main sequence.
	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_word <= '0;
		cfg_wen <= 1'b0;
		cfg_addr <= '0;
		cfg_wdata <= '0;
		rx_idle_on <= 1'b1;
		hold_go <= 1'b0;
		tx_idle_on = 1'b1;
		burst_left = 0;
		mismatch_count = 0;
		now_ms = 40'd200000;
		for (int i = 0; i < LINKS; i++) begin
			lk_state[i] = ST_UNKNOWN;
			lk_fail[i] = '0;
			lk_succ[i] = '0;
			lk_last[i] = '0;
			lk_warned[i] = 1'b0;
			lk_ready[i] = 1'b0;
			lk_socket[i] = 1'b0;
		end
		cfg_timeout = 12'd30;
		cfg_mult = RST_GRACE_MULT;
		cfg_min_fail = RST_MIN_FAIL;
		cfg_notices = RST_NOTICES;
		cfg_muted = RST_MUTED;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_basic_ops();
		test_outage_paths();
		test_register_extremes();
		test_random_phases();
		test_backpressure();

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Receiver stall pattern, with a long hold-off on request.
	initial begin : out_stall_driver
		rx_pattern_e pattern;
		int unsigned pattern_left, period, phase, hold_left;
		bit          hold_seen;
		pattern = RX_FLOW;
		pattern_left = 0;
		period = 2;
		phase = 0;
		hold_left = 0;
		hold_seen = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !hold_seen)
				hold_left = HOLD_CYCLES;
			hold_seen = hold_go;
			if (pattern_left == 0) begin
				pattern = rx_pattern_e'($urandom_range(0, 3));
				pattern_left = $urandom_range(8, 96);
				period = $urandom_range(2, 7);
			end
			pattern_left--;
			phase = (phase + 1) % period;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!rx_idle_on) begin
				out_stall <= 1'b0;
			end else begin
				case (pattern)
					RX_FLOW:     out_stall <= 1'b0;
					RX_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
					RX_PERIODIC: out_stall <= (phase == 0);
					default:     out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// Result checker: each accepted word against the oldest expectation.
	initial begin : result_checker
		out_word_t want, got;
		bit        bad;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got = out_word;
				if (pending_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("unexpected result word: %s", word_text(got));
				end else begin
					want = pending_results.pop_front();
					bad = (got.link_state !== want.link_state)
						|| (got.state_changed !== want.state_changed)
						|| (got.outage_start !== want.outage_start)
						|| (got.warning_shown !== want.warning_shown)
						|| (got.countdown_ms !== want.countdown_ms)
						|| (got.recovered_shown !== want.recovered_shown)
						|| (got.went_offline !== want.went_offline)
						|| (got.socket_up !== want.socket_up)
						|| (got.data_ready !== want.data_ready)
						|| (got.last_seen_ms !== want.last_seen_ms)
						|| (got.connected_count !== want.connected_count);
					if (bad) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS) begin
							$display("result mismatch at %0t", $realtime);
							$display("  expected %s", word_text(want));
							$display("  actual   %s", word_text(got));
						end
					end
				end
			end
		end
	end

	// Watchdog on the whole run.
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
